FILE: rtl/lru_key_value_cache_core_assert.svh
// Assertion macros used by the cache datapath.
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define LKVC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkvc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define LKVC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc: next-cycle check failed");

`endif

FILE: rtl/lkvc_pkg.sv
// Shared constants and controller/datapath interface types for the LRU cache.
`default_nettype none

package lkvc_pkg;

  // Default sizing
  localparam int DEF_MAX_ENTRIES = 8;
  localparam int DEF_VALUE_WIDTH = 32;

  // Fixed field widths
  localparam int KEY_W = 32;
  localparam int CAP_W = 4;

  // Capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // Operation codes
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;   // input transfer: capture item, restart scan
    logic scan_step;  // read one key entry and advance the scan index
    logic decide;     // choose action, issue reads for result data
    logic commit;     // update entries, ranks and result
    logic out_load;   // move result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // scan index is at the last entry
    logic out_free;   // output register can take a result this cycle
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/lkvc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lkvc_ctrl.sv
// Sequencing state machine for the LRU cache: handshake and datapath commands.
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN:  state_next = S_DECIDE;
      S_DECIDE: state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One item in flight; input is taken only while idle
  assign in_stall = (state != S_IDLE);

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.load_req  = (state == S_IDLE) && in_valid;
    cmd.scan_step = (state == S_SCAN);
    cmd.decide    = (state == S_DECIDE);
    cmd.commit    = (state == S_COMMIT);
    cmd.out_load  = (state == S_OUT) && stat.out_free;
  end

endmodule

`default_nettype wire

FILE: rtl/lkvc_datapath.sv
// Datapath of the LRU cache: entry storage, key scan, rank update, result registers.
`default_nettype none
`include "lru_key_value_cache_core_assert.svh"

module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output stat_t                 stat,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire logic             kind,
  input  wire logic [KEY_W-1:0] lookup_key,
  input  wire logic [KEY_W-1:0] put_value,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output logic                  found,
  output logic      [KEY_W-1:0] read_value,
  output logic                  evicted,
  output logic      [KEY_W-1:0] evicted_key
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Configuration
  logic [CAP_W-1:0] capacity_in_use;

  // Captured request
  logic                   req_get;
  logic [KEY_W-1:0]       req_key;
  logic [VALUE_WIDTH-1:0] req_val;
  logic [63:0]            put_wide;

  // Entry state
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0]       entry_rank [MAX_ENTRIES];
  logic [CNT_W-1:0]       held;

  // Scan
  logic [IDX_W-1:0] scan_idx;
  logic             cmp_en;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic             has_free;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] victim_idx;
  logic [IDX_W-1:0] oldest_rank;

  // Decision
  logic [7:0]       cap_ext;
  logic [7:0]       eff_cap;
  logic             at_cap;
  logic             do_get_hit;
  logic             do_put_hit;
  logic             do_evict;
  logic             do_insert;
  logic [IDX_W-1:0] slot;
  logic             age_en;
  logic [CNT_W-1:0] age_limit;

  // Memories
  logic [IDX_W-1:0]       key_raddr;
  logic                   key_re;
  logic [KEY_W-1:0]       key_rdata;
  logic                   key_we;
  logic                   val_we;
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic [63:0]            rd_wide;

  // Result
  logic             res_found;
  logic [KEY_W-1:0] res_rd;
  logic             res_ev;
  logic [KEY_W-1:0] res_evkey;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_in_use <= cfg_wdata;
    end
  end

  // Value kept to VALUE_WIDTH bits
  assign put_wide = 64'(put_value);

  // Request capture on input transfer
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_get <= (kind == KIND_GET);
      req_key <= lookup_key;
      req_val <= put_wide[VALUE_WIDTH-1:0];
    end
  end

  // Key and value stores
  assign key_raddr = cmd.decide ? victim_idx : scan_idx;
  assign key_re    = cmd.scan_step || cmd.decide;
  assign key_we    = cmd.commit && (do_evict || do_insert);
  assign val_we    = cmd.commit && (do_put_hit || do_evict || do_insert);

  lkvc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (slot),
    .wdata (req_key),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  lkvc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot),
    .wdata (req_val),
    .re    (cmd.decide),
    .raddr (hit_idx),
    .rdata (val_rdata)
  );

  // Least recent valid entry carries rank held-1
  assign oldest_rank = IDX_W'(held - CNT_W'(1));

  // Scan: one key per cycle, compare on the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en   <= 1'b0;
      hit      <= 1'b0;
      has_free <= 1'b0;
      scan_idx <= '0;
    end else begin
      cmp_en  <= cmd.scan_step;
      cmp_idx <= scan_idx;
      if (cmd.load_req) begin
        scan_idx <= '0;
        hit      <= 1'b0;
        has_free <= 1'b0;
      end else if (cmd.scan_step && !stat.scan_last) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmp_en) begin
        if (entry_valid[cmp_idx] && (key_rdata == req_key)) begin
          hit      <= 1'b1;
          hit_idx  <= cmp_idx;
          hit_rank <= entry_rank[cmp_idx];
        end
        if (!entry_valid[cmp_idx] && !has_free) begin
          has_free <= 1'b1;
          free_idx <= cmp_idx;
        end
        if (entry_valid[cmp_idx] && (entry_rank[cmp_idx] == oldest_rank)) begin
          victim_idx <= cmp_idx;
        end
      end
    end
  end

  // Effective capacity: zero acts as one, saturates at MAX_ENTRIES
  assign cap_ext = 8'(capacity_in_use);
  always_comb begin
    if (cap_ext == 8'd0) begin
      eff_cap = 8'd1;
    end else if (cap_ext > 8'(MAX_ENTRIES)) begin
      eff_cap = 8'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign at_cap = (8'(held) >= eff_cap);

  // Action choice
  always_ff @(posedge clk) begin
    if (rst) begin
      do_get_hit <= 1'b0;
      do_put_hit <= 1'b0;
      do_evict   <= 1'b0;
      do_insert  <= 1'b0;
    end else if (cmd.decide) begin
      do_get_hit <= req_get && hit;
      do_put_hit <= !req_get && hit;
      do_evict   <= !req_get && !hit && at_cap;
      do_insert  <= !req_get && !hit && !at_cap && has_free;
      if (hit) begin
        slot <= hit_idx;
      end else if (at_cap) begin
        slot <= victim_idx;
      end else begin
        slot <= free_idx;
      end
    end
  end

  // Aging limit per action; an insert ages every valid entry
  assign age_en = cmd.commit && (do_put_hit || do_evict || do_insert);
  always_comb begin
    if (do_put_hit) begin
      age_limit = CNT_W'(hit_rank);
    end else if (do_evict) begin
      age_limit = CNT_W'(oldest_rank);
    end else begin
      age_limit = CNT_W'(MAX_ENTRIES);
    end
  end

  // Per-entry rank and valid update
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      held        <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_rank[i] <= '0;
      end
    end else begin
      if (cmd.commit && do_insert) begin
        held <= held + CNT_W'(1);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (age_en && (IDX_W'(i) == slot)) begin
          entry_valid[i] <= 1'b1;
          entry_rank[i]  <= '0;
        end else if (age_en && entry_valid[i] && (CNT_W'(entry_rank[i]) < age_limit)) begin
          entry_rank[i] <= entry_rank[i] + IDX_W'(1);
        end
      end
    end
  end

  // Result capture
  assign rd_wide = 64'(val_rdata);
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_found <= do_get_hit || do_put_hit;
      res_rd    <= do_get_hit ? rd_wide[KEY_W-1:0] : '0;
      res_ev    <= do_evict;
      res_evkey <= do_evict ? key_rdata : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found       <= res_found;
      read_value  <= res_rd;
      evicted     <= res_ev;
      evicted_key <= res_evkey;
    end
  end

  // Status
  assign stat.scan_last = (scan_idx == IDX_W'(MAX_ENTRIES - 1));
  assign stat.out_free  = !out_valid || !out_stall;

  // Checks
  `LKVC_ASSERT_IMP(a_held_counts_valid, 1'b1, $countones(entry_valid) == int'(held))
  `LKVC_ASSERT_IMP(a_evict_slot_valid, cmd.commit && do_evict, entry_valid[slot])
  `LKVC_ASSERT_IMP(a_insert_slot_free, cmd.commit && do_insert, !entry_valid[slot])
  `LKVC_ASSERT_NEXT(a_slot_most_recent, age_en, entry_valid[slot] && (entry_rank[slot] == '0))

endmodule

`default_nettype wire

FILE: rtl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement.
// Each input transfer is a put (kind 0) or a get (kind 1); each gives exactly
// one result transfer. A put of a present key updates its value and makes it
// most recent; a put of a new key evicts the least recent entry once the
// number held reaches capacity_in_use (0 acts as 1, values above MAX_ENTRIES
// saturate), and reports the displaced key. A get reports found and the value
// and leaves recency alone. One item is processed at a time, paced by the key
// memory's single read port, which is scanned one entry per cycle. A finished
// result waits in the output register while the next item is taken. The
// capacity register is written with cfg_we/cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce.
// No clearing pass after reset.

module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic        [CAP_W-1:0] cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    kind,
  input  wire logic signed [KEY_W-1:0] lookup_key,
  input  wire logic signed [KEY_W-1:0] put_value,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         found,
  output logic signed      [KEY_W-1:0] read_value,
  output logic                         evicted,
  output logic signed      [KEY_W-1:0] evicted_key
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, scan and result path
  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .kind        (kind),
    .lookup_key  (lookup_key),
    .put_value   (put_value),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .found       (found),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

endmodule

`default_nettype wire

FILE: sim/lru_cache_checker.sv
// Checker for the LRU key-value cache: tracks cache contents and compares every result.
`default_nettype none

module lru_cache_checker
  import lkvc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic        [CAP_W-1:0] cfg_wdata,
  input  wire logic                    in_valid,
  input  wire logic                    in_stall,
  input  wire logic                    kind,
  input  wire logic signed [KEY_W-1:0] lookup_key,
  input  wire logic signed [KEY_W-1:0] put_value,
  input  wire logic                    out_valid,
  input  wire logic                    out_stall,
  input  wire logic                    found,
  input  wire logic signed [KEY_W-1:0] read_value,
  input  wire logic                    evicted,
  input  wire logic signed [KEY_W-1:0] evicted_key,
  output int                           mismatch_count,
  output int                           outstanding,
  output int                           results_checked,
  output int                           evictions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = DEF_MAX_ENTRIES;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } cache_result_t;

  // Shadow copy of the cache contents
  logic             slot_valid [SLOTS];
  logic [KEY_W-1:0] slot_key   [SLOTS];
  logic [KEY_W-1:0] slot_value [SLOTS];
  int unsigned      slot_rank  [SLOTS];  // 0 = most recently used
  int unsigned      held_count;
  logic [CAP_W-1:0] capacity_reg;

  cache_result_t pending_results[$];
  int            err_total;
  int            done_total;
  int            evict_total;

  initial begin
    mismatch_count  = 0;
    outstanding     = 0;
    results_checked = 0;
    evictions_seen  = 0;
    err_total       = 0;
    done_total      = 0;
    evict_total     = 0;
  end

  // Capacity as the cache applies it: zero acts as one, large values saturate
  function automatic int unsigned usable_capacity();
    if (capacity_reg == '0) return 1;
    if (capacity_reg > SLOTS) return SLOTS;
    return capacity_reg;
  endfunction

  // Make every valid entry younger than the limit one step older
  function automatic void age_ranks_below(int unsigned limit);
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_rank[i] < limit) slot_rank[i]++;
  endfunction

  // Apply one put or get to the shadow cache and return the result it should give
  function automatic cache_result_t apply_access(logic op, logic [KEY_W-1:0] key,
                                                 logic [KEY_W-1:0] val);
    cache_result_t res;
    int            hit;
    int            slot;
    int unsigned   oldest;
    res    = '0;
    hit    = -1;
    slot   = -1;
    oldest = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_valid[i] && slot_key[i] == key) hit = i;

    if (op == KIND_GET) begin
      // lookup leaves recency alone
      if (hit >= 0) begin
        res.found      = 1'b1;
        res.read_value = slot_value[hit];
      end
    end else if (hit >= 0) begin
      // update in place, becomes most recent
      res.found = 1'b1;
      age_ranks_below(slot_rank[hit]);
      slot_rank[hit]  = 0;
      slot_value[hit] = val;
    end else begin
      // new key: evict the oldest when full (also after capacity was lowered)
      if (held_count >= usable_capacity()) begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_valid[i] && (slot < 0 || slot_rank[i] > oldest)) begin
            slot   = i;
            oldest = slot_rank[i];
          end
        if (slot >= 0) begin
          res.evicted     = 1'b1;
          res.evicted_key = slot_key[slot];
          age_ranks_below(oldest);
        end
      end
      // otherwise take the lowest free slot
      if (slot < 0) begin
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!slot_valid[i]) slot = i;
        if (slot >= 0) begin
          age_ranks_below(SLOTS);
          held_count++;
        end
      end
      if (slot >= 0) begin
        slot_valid[slot] = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = val;
        slot_rank[slot]  = 0;
      end
    end
    return res;
  endfunction

  // Track transfers on both channels and the capacity register
  always @(posedge clk) begin : track
    cache_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_rank[i]  = 0;
      end
      held_count   = 0;
      capacity_reg = CAP_RESET;
      pending_results.delete();
    end else begin
      // result transfer: check against the oldest outstanding item
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with no item outstanding (found=%0b evicted=%0b)",
                   $time, found, evicted);
          err_total++;
        end else begin
          want = pending_results.pop_front();
          done_total++;
          if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, found);
            err_total++;
          end
          if (read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.read_value, read_value);
            err_total++;
          end
          if (evicted !== want.evicted) begin
            $display("%0t: evicted mismatch: expected %0b, actual %0b",
                     $time, want.evicted, evicted);
            err_total++;
          end
          if (evicted_key !== want.evicted_key) begin
            $display("%0t: evicted_key mismatch: expected %h, actual %h",
                     $time, want.evicted_key, evicted_key);
            err_total++;
          end
        end
      end

      if (cfg_we) capacity_reg = cfg_wdata;

      // input transfer: predict its result
      if (in_valid && !in_stall) begin
        want = apply_access(kind, lookup_key, put_value);
        if (want.evicted) evict_total++;
        pending_results.push_back(want);
      end
    end
    mismatch_count  <= err_total;
    outstanding     <= pending_results.size();
    results_checked <= done_total;
    evictions_seen  <= evict_total;
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Top-level testbench for the LRU key-value cache: stimulus, stalls, watchdog and verdict.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lkvc_pkg::*;

  localparam int SLOTS         = DEF_MAX_ENTRIES;
  localparam int ITEM_CYCLES   = SLOTS + 5;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int PHASE_ITEMS   = 73;
  localparam int PHASE_COUNT   = 10;
  localparam int POOL_MAX      = 14;

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    cfg_we      = 1'b0;
  logic        [CAP_W-1:0] cfg_wdata   = '0;
  logic                    in_valid    = 1'b0;
  logic                    kind        = KIND_PUT;
  logic signed [KEY_W-1:0] lookup_key  = '0;
  logic signed [KEY_W-1:0] put_value   = '0;
  logic                    out_stall   = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic                    found;
  logic signed [KEY_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  int mismatch_count;
  int outstanding;
  int results_checked;
  int evictions_seen;

  int   items_sent   = 0;
  int   idle_cycles  = 0;
  int   stall_left   = 0;
  logic quiet_phase  = 1'b0;  // no gaps on either side

  lru_key_value_cache_core i_dut (.*);

  lru_cache_checker i_checker (.*);

  always #4 clk = ~clk;

  // Mostly short gaps, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 14);
    return $urandom_range(15, 50);
  endfunction

  // Result-side stall pattern
  always @(posedge clk) begin
    int r;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 50) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 30);
      end else if (r < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(15, 60);
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: watchdog expired, no transfer for %0d cycles", $time, WATCHDOG_MAX);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input transfer, after an optional gap; valid stays high across back-to-back items
  task automatic send_access(input logic op, input logic [KEY_W-1:0] key,
                             input logic [KEY_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind       <= op;
    lookup_key <= key;
    put_value  <= val;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Wait for all results, let the block settle, then write the capacity
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (ITEM_CYCLES + 3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [PHASE_COUNT];
    logic [KEY_W-1:0] key_pool   [POOL_MAX];
    logic [KEY_W-1:0] key;
    int               pool_size;
    int               usable;

    phase_caps = '{4'd0, 4'd15, 4'd2, 4'd8, 4'd1, 4'd5, 4'd9, 4'd3, 4'd7, 4'd8};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty lookup, extreme keys and values, hits, misses, update, eviction
    send_access(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    send_access(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_access(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_access(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
    send_access(KIND_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(KIND_GET, 32'h8000_0000, 32'hFFFF_FFFF);  // value ignored on lookup
    send_access(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(KIND_GET, 32'h0000_3039, 32'h0000_0000);
    send_access(KIND_PUT, 32'h0000_0000, 32'h5A5A_5A5A);  // update refreshes recency
    send_access(KIND_GET, 32'h0000_0000, 32'h0000_0000);
    for (int i = 1; i <= 5; i++)
      send_access(KIND_PUT, i, $urandom);                 // last one evicts the oldest
    send_access(KIND_GET, 32'h8000_0000, 32'h0000_0000);  // evicted key now misses
    send_access(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_access(KIND_PUT, 32'h7FFF_FFFF, 32'h1234_5678);

    // Random phases over several capacities, including zero, max and lowering
    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_capacity(phase_caps[p]);
      quiet_phase = (p == 3 || p == 7);
      usable      = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > SLOTS ? SLOTS : phase_caps[p]);
      pool_size   = usable + $urandom_range(1, 5);
      if (pool_size > POOL_MAX) pool_size = POOL_MAX;
      for (int i = 0; i < POOL_MAX; i++) begin
        if (i == 0) key_pool[i] = 32'h8000_0000;
        else if (i == 1) key_pool[i] = 32'h7FFF_FFFF;
        else if ($urandom_range(0, 2) == 0) key_pool[i] = $urandom_range(0, 15);
        else key_pool[i] = $urandom;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 88) key = key_pool[$urandom_range(0, pool_size - 1)];
        else key = $urandom;
        send_access($urandom_range(0, 1) ? KIND_GET : KIND_PUT, key, $urandom);
      end
    end
    quiet_phase = 1'b0;

    // Drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (ITEM_CYCLES + 5) @(posedge clk);

    $display("Run covered %0d puts and gets over %0d capacity settings, %0d results checked",
             items_sent, PHASE_COUNT + 1, results_checked);
    $display("with %0d evictions and %0d mismatches", evictions_seen, mismatch_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: lru_key_value_cache_core.f
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lkvc_ctrl.sv
rtl/lkvc_datapath.sv
rtl/lru_key_value_cache_core.sv
sim/lru_cache_checker.sv
sim/testbench.sv
